// ===== rtl/core/dttn_pkg.sv =====
// Package for the decimal text to number converter.
// Holds character codes, character classes, status codes and shared types.
// No dependencies.
package dttn_pkg;

    // Fixed widths of the result fields.
    localparam int MANT_W   = 61;
    localparam int MAG_W    = 60;
    localparam int FRAC_W   = 4;
    localparam int STOP_W   = 13;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = MANT_W + FRAC_W + STOP_W + STATUS_W;

    // Default configuration values.
    localparam int DEF_MAX_FRAC_DIGITS = 9;
    localparam int DEF_MAX_STRING_LEN  = 4096;
    localparam int DEF_QUEUE_DEPTH     = 4;

    // Largest magnitude held, 10^18 - 1.
    localparam logic [MAG_W-1:0] MAG_MAX = 60'd999999999999999999;

    // Character codes.
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Character classes produced by the front end.
    localparam logic [2:0] CLS_BLANK = 3'd0;
    localparam logic [2:0] CLS_MINUS = 3'd1;
    localparam logic [2:0] CLS_DIGIT = 3'd2;
    localparam logic [2:0] CLS_POINT = 3'd3;
    localparam logic [2:0] CLS_OTHER = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    // One classified character as it travels from front end to back end.
    typedef struct packed {
        logic [2:0] cls;
        logic [3:0] digit;
        logic       last;
    } item_t;

endpackage

// ===== rtl/core/dttn_front.sv =====
// Front end of the converter: accepts characters and classifies them.
// Depends on dttn_pkg; feeds dttn_queue.
module dttn_front
(
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] char_code
    input  logic              s_axis_tlast,   // is_last
    input  logic              q_ready,
    output logic              q_push,
    output dttn_pkg::item_t   q_item
);
    import dttn_pkg::*;

    logic [7:0] digit_ofs;

    assign s_axis_tready = q_ready;
    assign q_push        = s_axis_tvalid & q_ready;
    assign digit_ofs     = s_axis_tdata - CHAR_ZERO;

    always_comb
    begin
        q_item.last  = s_axis_tlast;
        q_item.digit = 4'd0;
        unique case (s_axis_tdata) inside
            CHAR_SPACE, CHAR_PLUS, CHAR_TAB:
            begin
                q_item.cls = CLS_BLANK;
            end
            CHAR_MINUS:
            begin
                q_item.cls = CLS_MINUS;
            end
            CHAR_POINT:
            begin
                q_item.cls = CLS_POINT;
            end
            [CHAR_ZERO:CHAR_NINE]:
            begin
                q_item.cls   = CLS_DIGIT;
                q_item.digit = digit_ofs[3:0];
            end
            default:
            begin
                q_item.cls = CLS_OTHER;
            end
        endcase
    end

endmodule

// ===== rtl/core/dttn_queue.sv =====
// Short queue of classified characters between front end and back end.
// Depends on dttn_pkg for the item type.
module dttn_queue
#(
    parameter int DEPTH = dttn_pkg::DEF_QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dttn_pkg::item_t   push_item,
    output logic              ready,
    input  logic              pop,
    output logic              valid,
    output dttn_pkg::item_t   head_item
);
    import dttn_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready     = count_reg != CNT_W'(DEPTH);
    assign valid     = count_reg != '0;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/dttn_back.sv =====
// Back end of the converter: runs the parse state per character, then forms
// the signed result in a finishing stage and an output register.
// Depends on dttn_pkg; takes items from dttn_queue.
module dttn_back
#(
    parameter int MAX_FRAC_DIGITS = dttn_pkg::DEF_MAX_FRAC_DIGITS,
    parameter int MAX_STRING_LEN  = dttn_pkg::DEF_MAX_STRING_LEN
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  dttn_pkg::item_t           q_item,
    output logic                      q_pop,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [dttn_pkg::OUT_W-1:0] m_axis_tdata
);
    import dttn_pkg::*;

    localparam int POS_W  = $clog2(MAX_STRING_LEN + 1);
    localparam int FC_W   = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int SEXT_W = (POS_W > STOP_W) ? POS_W : STOP_W;
    localparam int FEXT_W = (FC_W > FRAC_W) ? FC_W : FRAC_W;

    localparam logic [2:0] PH_SKIP      = 3'd0;
    localparam logic [2:0] PH_INT       = 3'd1;
    localparam logic [2:0] PH_FRAC      = 3'd2;
    localparam logic [2:0] PH_FRAC_DROP = 3'd3;
    localparam logic [2:0] PH_DONE      = 3'd4;

    // Parse state.
    logic [2:0]       phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [FC_W-1:0]  fc_reg, fc_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] stop_reg, stop_next;
    logic             ovf_reg, ovf_next;

    // Finishing stage.
    logic                fin_valid_reg, fin_valid_next;
    logic                fin_neg_reg;
    logic [MAG_W-1:0]    fin_mag_reg;
    logic [FC_W-1:0]     fin_fc_reg;
    logic [POS_W-1:0]    fin_stop_reg;
    logic [STATUS_W-1:0] fin_status_reg;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [MANT_W-1:0]   out_mant_reg;
    logic [FRAC_W-1:0]   out_frac_reg;
    logic [STOP_W-1:0]   out_stop_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [63:0]        cand;
    logic               fits;
    logic               fin_move;
    logic               fin_load;
    logic [POS_W-1:0]   pos_step;
    logic [MANT_W-1:0]  mag_ext;
    logic [SEXT_W-1:0]  stop_ext;
    logic [FEXT_W-1:0]  fc_ext;

    // Magnitude times ten plus the digit, by shift and add.
    assign cand = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) + 64'(q_item.digit);
    assign fits = cand <= 64'(MAG_MAX);

    // Only the last character of a string needs a free finishing stage.
    assign fin_move = fin_valid_reg && (!out_valid_reg || m_axis_tready);
    assign q_pop    = q_valid && (!q_item.last || !fin_valid_reg || fin_move);
    assign fin_load = q_pop && q_item.last;
    assign pos_step = (pos_reg < POS_W'(MAX_STRING_LEN)) ? pos_reg + 1'b1 : pos_reg;

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        fc_next    = fc_reg;
        stop_next  = stop_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        if (q_pop)
        begin
            pos_next = pos_step;
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (q_item.cls == CLS_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_INT;
                    end
                    else if (q_item.cls == CLS_DIGIT)
                    begin
                        mag_next   = MAG_W'(q_item.digit);
                        phase_next = PH_INT;
                    end
                    else if (q_item.cls == CLS_POINT)
                    begin
                        phase_next = PH_FRAC;
                    end
                    else if (q_item.cls != CLS_BLANK)
                    begin
                        phase_next = PH_DONE;
                        stop_next  = pos_reg;
                    end
                end
                PH_INT:
                begin
                    if (q_item.cls == CLS_DIGIT)
                    begin
                        // Once saturated, further integer digits are consumed only.
                        if (!ovf_reg)
                        begin
                            if (fits)
                            begin
                                mag_next = cand[MAG_W-1:0];
                            end
                            else
                            begin
                                mag_next = MAG_MAX;
                                ovf_next = 1'b1;
                            end
                        end
                    end
                    else if (q_item.cls == CLS_POINT)
                    begin
                        phase_next = PH_FRAC;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                        stop_next  = pos_reg;
                    end
                end
                PH_FRAC:
                begin
                    if (q_item.cls == CLS_DIGIT)
                    begin
                        if (!ovf_reg && fc_reg < FC_W'(MAX_FRAC_DIGITS) && fits)
                        begin
                            mag_next = cand[MAG_W-1:0];
                            fc_next  = fc_reg + 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_FRAC_DROP;
                        end
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                        stop_next  = pos_reg;
                    end
                end
                PH_FRAC_DROP:
                begin
                    if (q_item.cls != CLS_DIGIT)
                    begin
                        phase_next = PH_DONE;
                        stop_next  = pos_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            fc_reg    <= '0;
            pos_reg   <= '0;
            stop_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (fin_load)
        begin
            // The string ends here, so the parse state starts over.
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            fc_reg    <= '0;
            pos_reg   <= '0;
            stop_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            fc_reg    <= fc_next;
            pos_reg   <= pos_next;
            stop_reg  <= stop_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        fin_valid_next = fin_valid_reg;
        if (fin_load)
        begin
            fin_valid_next = 1'b1;
        end
        else if (fin_move)
        begin
            fin_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            if (phase_next == PH_SKIP)
            begin
                fin_neg_reg    <= 1'b0;
                fin_mag_reg    <= '0;
                fin_fc_reg     <= '0;
                fin_stop_reg   <= pos_next;
                fin_status_reg <= ST_EMPTY;
            end
            else
            begin
                fin_neg_reg    <= neg_next;
                fin_mag_reg    <= mag_next;
                fin_fc_reg     <= fc_next;
                fin_stop_reg   <= (phase_next == PH_DONE) ? stop_next : pos_next;
                fin_status_reg <= ovf_next ? ST_OVERFLOW : ST_OK;
            end
        end
    end

    assign mag_ext  = {1'b0, fin_mag_reg};
    assign stop_ext = SEXT_W'(fin_stop_reg);
    assign fc_ext   = FEXT_W'(fin_fc_reg);

    always_ff @(posedge clk)
    begin
        if (fin_move)
        begin
            out_mant_reg   <= fin_neg_reg ? (~mag_ext + 1'b1) : mag_ext;
            out_frac_reg   <= fc_ext[FRAC_W-1:0];
            out_stop_reg   <= stop_ext[STOP_W-1:0];
            out_status_reg <= fin_status_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_status_reg, out_stop_reg, out_frac_reg, out_mant_reg};

endmodule

// ===== rtl/core/decimal_text_to_number_top.sv =====
// Top level of the decimal text to number converter.
// Depends on dttn_pkg, dttn_front, dttn_queue and dttn_back.
//
// The converter takes one ASCII character per request, with tlast on the final
// character of a string, and gives one result per string: a signed decimal
// mantissa, the number of fraction digits, the stop position and a status.
// It sustains one character per clock cycle while the queue has room; the
// figure is set by the back end, which folds each digit into the magnitude
// with one shift-and-add and one compare per cycle. A result passes through
// the queue write, then the parse update together with the finishing stage,
// then the output register before it is presented. Front and back are parted
// by a short queue, so input keeps flowing while a result waits on the output
// side, until the finishing stage also holds a result, a further string ends
// and the queue fills.
module decimal_text_to_number_top
#(
    parameter int MAX_FRAC_DIGITS = dttn_pkg::DEF_MAX_FRAC_DIGITS,
    parameter int MAX_STRING_LEN  = dttn_pkg::DEF_MAX_STRING_LEN,
    parameter int QUEUE_DEPTH     = dttn_pkg::DEF_QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // [7:0] char_code
    input  logic                       s_axis_tlast,  // is_last
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [60:0] mantissa, [64:61] frac_digits, [77:65] stop_position, [79:78] status
    output logic [dttn_pkg::OUT_W-1:0] m_axis_tdata
);
    import dttn_pkg::*;

    logic  q_ready;
    logic  q_push;
    item_t q_in_item;
    logic  q_valid;
    logic  q_pop;
    item_t q_head_item;

    dttn_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_item        (q_in_item)
    );

    dttn_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_item (q_head_item)
    );

    dttn_back
    #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .MAX_STRING_LEN  (MAX_STRING_LEN)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_head_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // The status field never carries an unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[79:78] != 2'd3)
    else $error("result status holds an unused code");

    // A blanks-only string always reports a zero value with no fraction digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[79:78] == ST_EMPTY)
        |-> (m_axis_tdata[64:0] == '0))
    else $error("empty result carries a nonzero value");

    // After integer overflow no fraction digit can be kept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[79:78] == ST_OVERFLOW)
        |-> (m_axis_tdata[64:61] == 4'd0))
    else $error("overflowed result keeps fraction digits");

    // The fraction digit count stays within its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[64:61] <= 4'(MAX_FRAC_DIGITS)))
    else $error("fraction digit count beyond its limit");

endmodule

// ===== sim/dttn_checker.sv =====
// Checker for the decimal text to number converter: watches both streams,
// parses each accepted character on its own and compares every result.
// Depends on dttn_pkg.
module dttn_checker
#(
    parameter int MAX_FRAC_DIGITS = dttn_pkg::DEF_MAX_FRAC_DIGITS,
    parameter int MAX_STRING_LEN  = dttn_pkg::DEF_MAX_STRING_LEN
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,
    input  logic                       s_axis_tlast,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [dttn_pkg::OUT_W-1:0] m_axis_tdata,
    output int                         mismatches,
    output int                         numbers_due
);

    import dttn_pkg::*;

    typedef enum logic [2:0] {
        SCAN_BLANKS,
        SCAN_INT,
        SCAN_FRAC,
        SCAN_FRAC_DROP,
        SCAN_DONE
    } scan_t;

    // Same layout as m_axis_tdata, status in the top bits.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [STOP_W-1:0]   stop;
        logic [FRAC_W-1:0]   frac;
        logic [MANT_W-1:0]   mant;
    } number_t;

    number_t           pending_numbers[$];
    scan_t             scan;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [FRAC_W-1:0] nfrac;
    logic [STOP_W-1:0] char_cnt;
    logic [STOP_W-1:0] stop_at;
    logic              saturated;

    function automatic logic digit_fits(input logic [MAG_W-1:0] m, input logic [3:0] d);
        return m <= (MAG_MAX - MAG_W'(d)) / MAG_W'(10);
    endfunction

    task automatic clear_number();
        scan      = SCAN_BLANKS;
        neg       = 1'b0;
        mag       = '0;
        nfrac     = '0;
        char_cnt  = '0;
        stop_at   = '0;
        saturated = 1'b0;
    endtask

    task automatic scan_char(input logic [7:0] c, input logic last);
        logic              is_dig;
        logic [3:0]        d;
        logic [MANT_W-1:0] wide;
        number_t           num;
        is_dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        d      = is_dig ? c[3:0] : 4'd0;
        case (scan)
            SCAN_BLANKS:
                if (c == CHAR_SPACE || c == CHAR_PLUS || c == CHAR_TAB) begin
                    scan = SCAN_BLANKS;
                end else if (c == CHAR_MINUS) begin
                    neg  = 1'b1;
                    scan = SCAN_INT;
                end else if (is_dig) begin
                    scan = SCAN_INT;
                    mag  = MAG_W'(d);
                end else if (c == CHAR_POINT) begin
                    scan = SCAN_FRAC;
                end else begin
                    scan    = SCAN_DONE;
                    stop_at = char_cnt;
                end
            SCAN_INT:
                if (is_dig) begin
                    // Once saturated, further integer digits are swallowed.
                    if (!saturated) begin
                        if (digit_fits(mag, d)) begin
                            mag = mag * MAG_W'(10) + MAG_W'(d);
                        end else begin
                            mag       = MAG_MAX;
                            saturated = 1'b1;
                        end
                    end
                end else if (c == CHAR_POINT) begin
                    scan = SCAN_FRAC;
                end else begin
                    scan    = SCAN_DONE;
                    stop_at = char_cnt;
                end
            SCAN_FRAC:
                if (is_dig) begin
                    if (!saturated && nfrac < MAX_FRAC_DIGITS && digit_fits(mag, d)) begin
                        mag   = mag * MAG_W'(10) + MAG_W'(d);
                        nfrac = nfrac + 1'b1;
                    end else begin
                        scan = SCAN_FRAC_DROP;
                    end
                end else begin
                    scan    = SCAN_DONE;
                    stop_at = char_cnt;
                end
            SCAN_FRAC_DROP:
                if (!is_dig) begin
                    scan    = SCAN_DONE;
                    stop_at = char_cnt;
                end
            default:
                scan = SCAN_DONE;
        endcase

        if (char_cnt < MAX_STRING_LEN)
            char_cnt = char_cnt + 1'b1;

        if (last) begin
            if (scan == SCAN_BLANKS) begin
                num.mant   = '0;
                num.frac   = '0;
                num.status = ST_EMPTY;
                num.stop   = char_cnt;
            end else begin
                wide       = {1'b0, mag};
                num.mant   = neg ? -wide : wide;
                num.frac   = nfrac;
                num.status = saturated ? ST_OVERFLOW : ST_OK;
                num.stop   = (scan == SCAN_DONE) ? stop_at : char_cnt;
            end
            pending_numbers.push_back(num);
            clear_number();
        end
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Sampling at the falling edge sees both handshakes settled.
    always @(negedge clk) begin
        number_t want;
        number_t got;
        if (!rst_n) begin
            clear_number();
            pending_numbers.delete();
            mismatches  = 0;
            numbers_due = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = number_t'(m_axis_tdata);
                if (pending_numbers.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = pending_numbers.pop_front();
                    check_field("mantissa", 64'($signed(want.mant)), 64'($signed(got.mant)));
                    check_field("frac_digits", 64'(want.frac), 64'(got.frac));
                    check_field("stop_position", 64'(want.stop), 64'(got.stop));
                    check_field("status", 64'(want.status), 64'(got.status));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                scan_char(s_axis_tdata, s_axis_tlast);
            numbers_due = pending_numbers.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the decimal text to number converter: sends directed and
// random strings, stalls the result side and gives the verdict.
// Depends on dttn_pkg, decimal_text_to_number_top and dttn_checker.
module tb_top;

    import dttn_pkg::*;

    localparam int RANDOM_CHARS = 1000;
    localparam int QUIET_LIMIT  = 5000;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;
    logic             s_axis_tlast;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    int               mismatches;
    int               numbers_due;
    int               chars_sent;
    int               strings_sent;
    int               quiet_cycles;
    logic             calm;
    logic [7:0]       text_q[$];

    decimal_text_to_number_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    dttn_checker chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .numbers_due   (numbers_due)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 22);
    end

    // Ends the run when neither side moves a request for too long.
    always @(negedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic void add_digits(input int n);
        for (int i = 0; i < n; i++)
            text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void add_blanks(input int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 2);
            text_q.push_back(pick == 0 ? CHAR_SPACE : (pick == 1 ? CHAR_PLUS : CHAR_TAB));
        end
    endfunction

    function automatic void add_noise(input int n);
        for (int i = 0; i < n; i++)
            text_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // A well-formed number with random content, now and then trailing junk.
    function automatic void add_number();
        int pick;
        pick = $urandom_range(0, 99);
        add_blanks($urandom_range(0, 3));
        if ($urandom_range(0, 2) == 0)
            text_q.push_back(CHAR_MINUS);
        add_digits(pick < 15 ? $urandom_range(16, 24) : $urandom_range(0, 6));
        if ($urandom_range(0, 3) != 0)
        begin
            text_q.push_back(CHAR_POINT);
            add_digits(pick >= 80 ? $urandom_range(8, 14) : $urandom_range(0, 5));
        end
        if ($urandom_range(0, 3) == 0)
            add_noise($urandom_range(1, 3));
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        logic taken;
        while (!calm && $urandom_range(0, 99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
        chars_sent++;
    endtask

    task automatic send_text();
        if (text_q.size() == 0)
            add_noise(1);
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
        strings_sent++;
    endtask

    initial
    begin
        int stop_chars;
        int pick;
        int spot;
        rst_n         = 1'b0;
        calm          = 1'b0;
        chars_sent    = 0;
        strings_sent  = 0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Blanks only, a bare minus, negative zero and the largest magnitude.
        add_text(" \t+");
        send_text();
        add_text("-");
        send_text();
        add_text("-0");
        send_text();
        add_text("999999999999999999");
        send_text();
        // Integer overflow, then excess fraction digits.
        add_text("-12345678901234567890.5");
        send_text();
        add_text("1.1234567891");
        send_text();
        add_text(".5");
        send_text();
        // Code zero and code 255 are ordinary stop characters.
        text_q.push_back(8'h00);
        send_text();
        add_text("7");
        text_q.push_back(8'hFF);
        send_text();
        add_text("+-5.2.3");
        send_text();
        add_text("--1");
        send_text();

        stop_chars = chars_sent + RANDOM_CHARS;
        while (chars_sent < stop_chars)
        begin
            calm <= (strings_sent >= 40 && strings_sent < 70);
            pick = $urandom_range(0, 99);
            if (pick < 62)
            begin
                add_number();
            end
            else if (pick < 72)
            begin
                add_blanks($urandom_range(1, 4));
                if ($urandom_range(0, 1) == 0)
                    text_q.push_back($urandom_range(0, 1) == 0 ? CHAR_MINUS : CHAR_POINT);
            end
            else if (pick < 86)
            begin
                add_noise($urandom_range(1, 8));
            end
            else
            begin
                // A number with one character replaced by noise.
                add_number();
                if (text_q.size() != 0)
                begin
                    spot = $urandom_range(0, text_q.size() - 1);
                    text_q[spot] = 8'($urandom_range(0, 255));
                end
            end
            send_text();
        end
        calm <= 1'b0;

        s_axis_tvalid <= 1'b0;
        while (numbers_due != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
